FILE: hdl/blpc_pkg.sv
package blpc_pkg;

    // panel geometry
    localparam int LedCount   = 40;
    localparam int GroupCount = 5;

    typedef logic [GroupCount-1:0][7:0] img_t;

    // command codes
    typedef enum logic [3:0] {
        CMD_SET          = 4'd0,
        CMD_CLEAR        = 4'd1,
        CMD_TEST         = 4'd2,
        CMD_BLINK_SET    = 4'd3,
        CMD_BLINK_CLEAR  = 4'd4,
        CMD_BLINK_TEST   = 4'd5,
        CMD_LOAD         = 4'd6,
        CMD_TICK         = 4'd7,
        CMD_SAVE         = 4'd8,
        CMD_RESTORE      = 4'd9,
        CMD_BLINK_STATUS = 4'd10
    } cmd_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
    } dp_cmd_t;

    // logical led number to {byte, bit}
    localparam logic [5:0] LED_MAP [LedCount] = '{
        6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,  6'd7,  6'd24, 6'd25,
        6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd26, 6'd27,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd28, 6'd29,
        6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd30, 6'd31
    };

    // change pulse bit for a valid led number
    function automatic logic [3:0] group_pulse(input logic [7:0] n);
        logic [3:0] g;
        if (n < 8'd10)
            g = 4'b0001;
        else if (n < 8'd20)
            g = 4'b0010;
        else if (n < 8'd30)
            g = 4'b0100;
        else
            g = 4'b1000;
        return g;
    endfunction

endpackage

FILE: hdl/blpc_ctrl.sv
module blpc_ctrl
    import blpc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output dp_cmd_t dp_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // output slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        dp_cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    dp_cmd.capture = 1'b1;
                    state_next     = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    dp_cmd.execute = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: hdl/blpc_datapath.sv
module blpc_datapath
    import blpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    dp_cmd,
    input  logic [3:0] command,
    input  logic [7:0] led_number,
    input  logic [7:0] red_byte,
    input  logic [7:0] green_byte,
    input  logic [7:0] control_byte,
    input  logic [7:0] mixer_byte,
    input  logic [7:0] group_byte,
    output logic       led_is_set,
    output logic [7:0] red_pins,
    output logic [7:0] green_pins,
    output logic [7:0] control_pins,
    output logic [7:0] mixer_pins,
    output logic [7:0] group_pins,
    output logic [7:0] change_pulses,
    output logic [7:0] blink_green_status,
    output logic [1:0] blink_extra_status
);

    // captured transaction
    logic [3:0] cmd_reg;
    logic [7:0] num_reg;
    img_t       load_reg;

    // panel state
    img_t on_reg, on_next;
    img_t blink_reg, blink_next;
    img_t saved_on_reg, saved_on_next;
    img_t saved_blink_reg, saved_blink_next;
    img_t pin_reg, pin_next;
    logic phase_reg, phase_next;

    // result registers
    logic       is_set_reg, is_set_next;
    img_t       res_pins_reg;
    logic [7:0] pulses_reg, pulses_next;
    logic [7:0] gstat_reg, gstat_next;
    logic [1:0] xstat_reg, xstat_next;

    // led lookup
    logic       num_ok;
    logic [5:0] map;
    logic [2:0] byte_idx;
    logic [2:0] bit_idx;
    logic [3:0] grp;
    logic       on_cur;
    logic       blink_cur;

    assign num_ok    = (num_reg < 8'(LedCount));
    assign map       = LED_MAP[num_ok ? num_reg[5:0] : 6'd0];
    assign byte_idx  = map[5:3];
    assign bit_idx   = map[2:0];
    assign grp       = group_pulse(num_reg);
    assign on_cur    = on_reg[byte_idx][bit_idx];
    assign blink_cur = blink_reg[byte_idx][bit_idx];

    // command execution
    always_comb
    begin
        on_next          = on_reg;
        blink_next       = blink_reg;
        saved_on_next    = saved_on_reg;
        saved_blink_next = saved_blink_reg;
        pin_next         = pin_reg;
        phase_next       = phase_reg;
        is_set_next      = 1'b0;
        pulses_next      = 8'h00;
        gstat_next       = 8'h00;
        xstat_next       = 2'b00;
        case (cmd_reg)
            CMD_SET:
            begin
                if (num_ok && !on_cur)
                begin
                    on_next[byte_idx][bit_idx] = 1'b1;
                    pulses_next                = {4'b0000, grp};
                end
            end
            CMD_CLEAR:
            begin
                if (num_ok && on_cur)
                begin
                    on_next[byte_idx][bit_idx] = 1'b0;
                    pulses_next                = {4'b0000, grp};
                end
            end
            CMD_TEST:
            begin
                is_set_next = num_ok && on_cur;
            end
            CMD_BLINK_SET:
            begin
                if (num_ok && !blink_cur)
                begin
                    blink_next[byte_idx][bit_idx] = 1'b1;
                    pulses_next                   = {grp, 4'b0000};
                end
            end
            CMD_BLINK_CLEAR:
            begin
                if (num_ok && blink_cur)
                begin
                    blink_next[byte_idx][bit_idx] = 1'b0;
                    pulses_next                   = {grp, 4'b0000};
                end
            end
            CMD_BLINK_TEST:
            begin
                is_set_next = num_ok && blink_cur;
            end
            CMD_LOAD:
            begin
                on_next     = load_reg;
                pulses_next = 8'h0F;
            end
            CMD_TICK:
            begin
                phase_next = !phase_reg;
                for (int i = 0; i < GroupCount; i++)
                begin
                    pin_next[i] = phase_next ? ~on_reg[i] : ~(on_reg[i] ^ blink_reg[i]);
                end
            end
            CMD_SAVE:
            begin
                saved_on_next    = on_reg;
                saved_blink_next = blink_reg;
            end
            CMD_RESTORE:
            begin
                on_next     = saved_on_reg;
                blink_next  = saved_blink_reg;
                pulses_next = 8'hFF;
            end
            CMD_BLINK_STATUS:
            begin
                gstat_next = blink_reg[1];
                xstat_next = blink_reg[3][3:2];
            end
            default:
            begin
            end
        endcase
    end

    // transaction capture, bulk bytes stored in image order except that mixer and group land swapped
    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            cmd_reg  <= command;
            num_reg  <= led_number;
            load_reg <= {mixer_byte, group_byte, control_byte, green_byte, red_byte};
        end
    end

    // panel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg          <= '0;
            blink_reg       <= '0;
            saved_on_reg    <= '0;
            saved_blink_reg <= '0;
            pin_reg         <= '1;
            phase_reg       <= 1'b1;
        end
        else if (dp_cmd.execute)
        begin
            on_reg          <= on_next;
            blink_reg       <= blink_next;
            saved_on_reg    <= saved_on_next;
            saved_blink_reg <= saved_blink_next;
            pin_reg         <= pin_next;
            phase_reg       <= phase_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (dp_cmd.execute)
        begin
            is_set_reg   <= is_set_next;
            res_pins_reg <= pin_next;
            pulses_reg   <= pulses_next;
            gstat_reg    <= gstat_next;
            xstat_reg    <= xstat_next;
        end
    end

    assign led_is_set         = is_set_reg;
    assign red_pins           = res_pins_reg[0];
    assign green_pins         = res_pins_reg[1];
    assign control_pins       = res_pins_reg[2];
    assign mixer_pins         = res_pins_reg[3];
    assign group_pins         = res_pins_reg[4];
    assign change_pulses      = pulses_reg;
    assign blink_green_status = gstat_reg;
    assign blink_extra_status = xstat_reg;

endmodule

FILE: hdl/blinking_led_panel_controller_core.sv
// Blinking LED panel controller, 40 LEDs in five 8-bit groups.
// Input channel (in_valid / in_stall) carries one command per transaction:
// set, clear or test an LED or its blink bit, bulk load, refresh tick,
// save, restore or blink status read.
// Output channel (out_valid / out_stall) returns exactly one result per
// command: test answer, the registered active-low pins, change pulses per
// group and the blink status bytes.
// The command is captured when accepted; it executes into the output register
// once that register is free. Commands are not overlapped: the capture and
// execute steps of the controller sequence alternate.
// The result sits in an output register, so a new command is accepted
// while the previous result still waits; if the receiver stalls, the
// next command waits in its execute cycle until the output register drains.
// Reset clears both images and their saved copies, sets the blink phase
// and sets the pin image high (LEDs off); the pin outputs are not reset.
module blinking_led_panel_controller_core
    import blpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [3:0] command,
    input  logic [7:0] led_number,
    input  logic [7:0] red_byte,
    input  logic [7:0] green_byte,
    input  logic [7:0] control_byte,
    input  logic [7:0] mixer_byte,
    input  logic [7:0] group_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       led_is_set,
    output logic [7:0] red_pins,
    output logic [7:0] green_pins,
    output logic [7:0] control_pins,
    output logic [7:0] mixer_pins,
    output logic [7:0] group_pins,
    output logic [7:0] change_pulses,
    output logic [7:0] blink_green_status,
    output logic [1:0] blink_extra_status
);

    dp_cmd_t dp_cmd;

    blpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_cmd    (dp_cmd)
    );

    blpc_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .dp_cmd             (dp_cmd),
        .command            (command),
        .led_number         (led_number),
        .red_byte           (red_byte),
        .green_byte         (green_byte),
        .control_byte       (control_byte),
        .mixer_byte         (mixer_byte),
        .group_byte         (group_byte),
        .led_is_set         (led_is_set),
        .red_pins           (red_pins),
        .green_pins         (green_pins),
        .control_pins       (control_pins),
        .mixer_pins         (mixer_pins),
        .group_pins         (group_pins),
        .change_pulses      (change_pulses),
        .blink_green_status (blink_green_status),
        .blink_extra_status (blink_extra_status)
    );

`ifndef NO_ASSERTIONS
    // an accepted command is executed before the next one is taken
    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("command accepted without entering execute");

    // execution never overwrites a result that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.execute |-> (!out_valid || !out_stall))
        else $error("result overwritten while stalled");

    // a new result only follows an execute cycle
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(dp_cmd.execute))
        else $error("result valid without execute");

    // capture and execute never coincide
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(dp_cmd.capture && dp_cmd.execute))
        else $error("capture and execute in the same cycle");
`endif

endmodule

FILE: tb/tb_blinking_led_panel_controller_core.sv
`timescale 1ns / 1ps

module tb_blinking_led_panel_controller_core;
    import blpc_pkg::*;

    // command codes with no defined action
    localparam logic [3:0] OP_SPARE_FIRST = 4'd11;
    localparam logic [3:0] OP_SPARE_LAST  = 4'd15;

    localparam int RANDOM_ITEMS = 950;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_LIMIT  = 40;

    // one command transaction as presented on the input channel
    typedef struct packed {
        logic [3:0] op;
        logic [7:0] num;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] ctl;
        logic [7:0] mix;
        logic [7:0] grp;
        logic       hold;
        logic       quiet;
    } panel_cmd_t;

    // one result transaction
    typedef struct packed {
        logic       is_set;
        img_t       pins;
        logic [7:0] pulses;
        logic [7:0] green_stat;
        logic [1:0] extra_stat;
    } panel_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [3:0] command = '0;
    logic [7:0] led_number = '0;
    logic [7:0] red_byte = '0;
    logic [7:0] green_byte = '0;
    logic [7:0] control_byte = '0;
    logic [7:0] mixer_byte = '0;
    logic [7:0] group_byte = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       led_is_set;
    logic [7:0] red_pins;
    logic [7:0] green_pins;
    logic [7:0] control_pins;
    logic [7:0] mixer_pins;
    logic [7:0] group_pins;
    logic [7:0] change_pulses;
    logic [7:0] blink_green_status;
    logic [1:0] blink_extra_status;

    blinking_led_panel_controller_core dut (.*);

    // predicted panel state
    img_t on_img;
    img_t blink_img;
    img_t save_on;
    img_t save_blink;
    img_t pins_img;
    logic phase;

    panel_cmd_t    pending_q[$];
    panel_result_t panel_exp_q[$];
    int            sent_cnt = 0;
    int            seen_cnt = 0;
    int            err_cnt = 0;
    int            gap_left = 0;
    int            stall_left = 0;
    int            idle_cycles = 0;
    logic          burst_mode = 1'b0;

    logic in_fire;
    logic out_fire;
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;

    // clock
    initial begin
        forever #2 clk = ~clk;
    end

    // logical led number to bit position {byte, bit}
    function automatic logic [5:0] led_slot(input logic [7:0] n);
        logic [5:0] s;
        if (n < 8)
            s = n[5:0];
        else if (n < 10)
            s = 6'(n + 16);
        else if (n < 18)
            s = 6'(n - 2);
        else if (n < 20)
            s = 6'(n + 8);
        else if (n < 28)
            s = 6'(n - 4);
        else if (n < 30)
            s = n[5:0];
        else if (n < 38)
            s = 6'(n + 2);
        else
            s = 6'(n - 8);
        return s;
    endfunction

    // set or clear one led bit, give the group change pulse
    function automatic logic [3:0] write_led(inout img_t img, input logic [7:0] n,
                                             input logic on);
        logic [5:0] s;
        if (n >= LedCount)
            return 4'b0000;
        s = led_slot(n);
        if (img[s[5:3]][s[2:0]] == on)
            return 4'b0000;
        img[s[5:3]][s[2:0]] = on;
        return 4'b0001 << (n / 10);
    endfunction

    function automatic logic read_led(input img_t img, input logic [7:0] n);
        logic [5:0] s;
        s = led_slot(n);
        return (n < LedCount) ? img[s[5:3]][s[2:0]] : 1'b0;
    endfunction

    // advance the predicted panel by one command
    function automatic panel_result_t step_panel(input panel_cmd_t c);
        panel_result_t r;
        r = '0;
        case (c.op)
            CMD_SET:          r.pulses[3:0] = write_led(on_img, c.num, 1'b1);
            CMD_CLEAR:        r.pulses[3:0] = write_led(on_img, c.num, 1'b0);
            CMD_TEST:         r.is_set = read_led(on_img, c.num);
            CMD_BLINK_SET:    r.pulses[7:4] = write_led(blink_img, c.num, 1'b1);
            CMD_BLINK_CLEAR:  r.pulses[7:4] = write_led(blink_img, c.num, 1'b0);
            CMD_BLINK_TEST:   r.is_set = read_led(blink_img, c.num);
            CMD_LOAD:
            begin
                // mixer and group bytes land swapped
                on_img[0] = c.red;
                on_img[1] = c.green;
                on_img[2] = c.ctl;
                on_img[3] = c.grp;
                on_img[4] = c.mix;
                r.pulses = 8'h0F;
            end
            CMD_TICK:
            begin
                phase = ~phase;
                for (int i = 0; i < GroupCount; i++)
                    pins_img[i] = phase ? ~on_img[i] : ~(on_img[i] ^ blink_img[i]);
            end
            CMD_SAVE:
            begin
                save_on = on_img;
                save_blink = blink_img;
            end
            CMD_RESTORE:
            begin
                on_img = save_on;
                blink_img = save_blink;
                r.pulses = 8'hFF;
            end
            CMD_BLINK_STATUS:
            begin
                r.green_stat = blink_img[1];
                r.extra_stat = blink_img[3][3:2];
            end
            default: ;
        endcase
        r.pins = pins_img;
        return r;
    endfunction

    function automatic panel_cmd_t mk_cmd(input logic [3:0] op, input logic [7:0] num);
        panel_cmd_t c;
        c.op = op;
        c.num = num;
        c.red = 8'($urandom);
        c.green = 8'($urandom);
        c.ctl = 8'($urandom);
        c.mix = 8'($urandom);
        c.grp = 8'($urandom);
        c.hold = 1'b0;
        c.quiet = 1'b0;
        return c;
    endfunction

    function automatic panel_cmd_t mk_load(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] c, input logic [7:0] m,
                                           input logic [7:0] grp);
        panel_cmd_t item;
        item = mk_cmd(CMD_LOAD, 8'($urandom));
        item.red = r;
        item.green = g;
        item.ctl = c;
        item.mix = m;
        item.grp = grp;
        return item;
    endfunction

    function automatic logic [3:0] pick_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 14) return CMD_SET;
        if (r < 26) return CMD_CLEAR;
        if (r < 36) return CMD_TEST;
        if (r < 46) return CMD_BLINK_SET;
        if (r < 54) return CMD_BLINK_CLEAR;
        if (r < 62) return CMD_BLINK_TEST;
        if (r < 68) return CMD_LOAD;
        if (r < 80) return CMD_TICK;
        if (r < 85) return CMD_SAVE;
        if (r < 90) return CMD_RESTORE;
        if (r < 96) return CMD_BLINK_STATUS;
        return 4'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    endfunction

    // mostly real leds, some out of range
    function automatic logic [7:0] pick_num();
        if ($urandom_range(0, 99) < 85)
            return 8'($urandom_range(0, LedCount - 1));
        return 8'($urandom_range(LedCount, 255));
    endfunction

    // idle length: mostly short, a few long
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic report_mismatch(input string what, input int idx,
                                   input logic [7:0] got, input logic [7:0] want);
        if (err_cnt < PRINT_LIMIT)
            $display("result %0d: %s got %h expected %h", idx, what, got, want);
        err_cnt++;
    endtask

    // input driver: predicts each accepted transaction, then presents the next
    always @(posedge clk or negedge rst_n) begin : drv_proc
        panel_cmd_t cur;
        panel_cmd_t nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
            command <= '0;
            led_number <= '0;
            red_byte <= '0;
            green_byte <= '0;
            control_byte <= '0;
            mixer_byte <= '0;
            group_byte <= '0;
            gap_left <= 0;
            sent_cnt <= 0;
            burst_mode <= 1'b0;
            on_img = '0;
            blink_img = '0;
            save_on = '0;
            save_blink = '0;
            pins_img = '1;
            phase = 1'b1;
        end
        else begin
            if (in_fire) begin
                cur = '0;
                cur.op = command;
                cur.num = led_number;
                cur.red = red_byte;
                cur.green = green_byte;
                cur.ctl = control_byte;
                cur.mix = mixer_byte;
                cur.grp = group_byte;
                panel_exp_q.push_back(step_panel(cur));
                sent_cnt <= sent_cnt + 1;
            end
            if (!in_valid || in_fire) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() != 0 &&
                         (!pending_q[0].hold || (!in_fire && seen_cnt == sent_cnt))) begin
                    nxt = pending_q.pop_front();
                    command <= nxt.op;
                    led_number <= nxt.num;
                    red_byte <= nxt.red;
                    green_byte <= nxt.green;
                    control_byte <= nxt.ctl;
                    mixer_byte <= nxt.mix;
                    group_byte <= nxt.grp;
                    in_valid <= 1'b1;
                    burst_mode <= nxt.quiet;
                    gap_left <= nxt.quiet ? 0 : pick_gap();
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n) begin : mon_proc
        panel_result_t want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left <= 0;
            seen_cnt <= 0;
        end
        else begin
            if (out_fire) begin
                if (seen_cnt >= sent_cnt) begin
                    report_mismatch("unexpected result", seen_cnt, 8'h00, 8'h00);
                end
                else begin
                    want = panel_exp_q[seen_cnt];
                    if (led_is_set !== want.is_set)
                        report_mismatch("led_is_set", seen_cnt, 8'(led_is_set),
                                        8'(want.is_set));
                    if (red_pins !== want.pins[0])
                        report_mismatch("red_pins", seen_cnt, red_pins, want.pins[0]);
                    if (green_pins !== want.pins[1])
                        report_mismatch("green_pins", seen_cnt, green_pins, want.pins[1]);
                    if (control_pins !== want.pins[2])
                        report_mismatch("control_pins", seen_cnt, control_pins, want.pins[2]);
                    if (mixer_pins !== want.pins[3])
                        report_mismatch("mixer_pins", seen_cnt, mixer_pins, want.pins[3]);
                    if (group_pins !== want.pins[4])
                        report_mismatch("group_pins", seen_cnt, group_pins, want.pins[4]);
                    if (change_pulses !== want.pulses)
                        report_mismatch("change_pulses", seen_cnt, change_pulses, want.pulses);
                    if (blink_green_status !== want.green_stat)
                        report_mismatch("blink_green_status", seen_cnt, blink_green_status,
                                        want.green_stat);
                    if (blink_extra_status !== want.extra_stat)
                        report_mismatch("blink_extra_status", seen_cnt,
                                        8'(blink_extra_status), 8'(want.extra_stat));
                    seen_cnt <= seen_cnt + 1;
                end
            end
            if (burst_mode) begin
                out_stall <= 1'b0;
                stall_left <= 0;
            end
            else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0)
                    stall_left <= pick_gap();
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk) begin
        if (!rst_n || in_fire || out_fire) begin
            idle_cycles <= 0;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin : stim_proc
        panel_cmd_t item;

        // directed: bulk load swap, both phases, range edges, no-effect writes
        pending_q.push_back(mk_load(8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hC3));
        pending_q.push_back(mk_cmd(CMD_TICK, 8'd0));
        pending_q.push_back(mk_cmd(CMD_TICK, 8'd0));
        pending_q.push_back(mk_cmd(CMD_CLEAR, 8'd0));
        pending_q.push_back(mk_cmd(CMD_CLEAR, 8'd0));
        pending_q.push_back(mk_cmd(CMD_SET, 8'd39));
        pending_q.push_back(mk_cmd(CMD_SET, 8'd40));
        pending_q.push_back(mk_cmd(CMD_SET, 8'd255));
        pending_q.push_back(mk_cmd(CMD_TEST, 8'd39));
        pending_q.push_back(mk_cmd(CMD_TEST, 8'd40));
        pending_q.push_back(mk_cmd(CMD_TEST, 8'd255));
        pending_q.push_back(mk_cmd(CMD_BLINK_SET, 8'd18));
        pending_q.push_back(mk_cmd(CMD_BLINK_SET, 8'd19));
        pending_q.push_back(mk_cmd(CMD_BLINK_SET, 8'd10));
        pending_q.push_back(mk_cmd(CMD_BLINK_SET, 8'd10));
        pending_q.push_back(mk_cmd(CMD_TICK, 8'd0));
        pending_q.push_back(mk_cmd(CMD_BLINK_TEST, 8'd18));
        pending_q.push_back(mk_cmd(CMD_BLINK_TEST, 8'd250));
        pending_q.push_back(mk_cmd(CMD_BLINK_STATUS, 8'd0));
        pending_q.push_back(mk_cmd(CMD_SAVE, 8'd0));
        pending_q.push_back(mk_load(8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h3C));
        pending_q.push_back(mk_cmd(CMD_RESTORE, 8'd0));
        pending_q.push_back(mk_cmd(CMD_BLINK_CLEAR, 8'd19));
        pending_q.push_back(mk_cmd(CMD_BLINK_CLEAR, 8'd41));
        pending_q.push_back(mk_cmd(OP_SPARE_FIRST, 8'd7));
        pending_q.push_back(mk_cmd(OP_SPARE_LAST, 8'd200));

        // random commands; one stretch with no idling, a few drain pauses
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            item = mk_cmd(pick_op(), pick_num());
            item.quiet = (k >= 300 && k < 400);
            item.hold = (k == 0) || (k == 600) || ($urandom_range(0, 199) == 0);
            pending_q.push_back(item);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pending_q.size() != 0 || in_valid || seen_cnt != sent_cnt);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
